// ===== src/rbc_pkg.sv =====
// rbc_pkg: shared constants, types and helpers of the rounded border coverage block
// used by rbc_front, rbc_queue, rbc_back and rounded_border_coverage
// no dependencies
package rbc_pkg;

    // frame buffer and coverage format
    localparam int FB_WIDTH  = 1024;
    localparam int FB_HEIGHT = 1024;
    localparam int COV_BITS  = 8;

    // signed coordinate width, wide enough for left edge plus width plus radius
    localparam int CW = 19;

    // quotient, numerator and divisor widths of the coverage ratio
    localparam int QW   = COV_BITS + 1;
    localparam int NUMW = 9;
    localparam int DW   = NUMW + 1;
    localparam int NW   = NUMW + COV_BITS + 2;
    localparam int DSQW = 17;

    // descriptor queue and result queue depths
    localparam int Q_DEPTH  = 4;
    localparam int QPW      = $clog2(Q_DEPTH);
    localparam int OF_DEPTH = 16;
    localparam int OPW      = $clog2(OF_DEPTH);

    localparam logic [QW-1:0] FULL_COV = QW'(2 ** COV_BITS);

    // register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_RECT_X = 3'd0;
    localparam logic [CFG_IW-1:0] REG_RECT_Y = 3'd1;
    localparam logic [CFG_IW-1:0] REG_CLIP_X = 3'd2;
    localparam logic [CFG_IW-1:0] REG_CLIP_Y = 3'd3;
    localparam logic [CFG_IW-1:0] REG_RADIUS = 3'd4;
    localparam logic [CFG_IW-1:0] REG_BORDER = 3'd5;
    localparam logic [CFG_IW-1:0] REG_COLOR  = 3'd6;

    // geometry settings seen by the front and back
    typedef struct packed {
        logic [31:0] rect_x_span;
        logic [31:0] rect_y_span;
        logic [31:0] clip_x_span;
        logic [31:0] clip_y_span;
        logic [7:0]  corner_radius;
        logic [7:0]  border_thickness;
    } cfg_t;

    // one write to be made: solid edge or corner at offset dx, dy
    typedef struct packed {
        logic       corner;
        logic [7:0] dx;
        logic [7:0] dy;
    } slot_t;

    // one classified pixel with its writes in drawing order
    typedef struct packed {
        logic [11:0]     x;
        logic [11:0]     y;
        logic [2:0]      cnt;
        slot_t [3:0]     slot;
    } desc_t;

    // one finished write
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [8:0]  cov;
        logic        last;
    } res_t;

    // clamp coverage to the 9-bit output
    function automatic logic [8:0] sat_cov(logic [QW-1:0] v);
        if (32'(v) > 32'd511)
            return 9'd511;
        return 9'(v);
    endfunction

endpackage

// ===== src/rbc_queue.sv =====
// rbc_queue: short descriptor queue between front and back
// depends on rbc_pkg
module rbc_queue
    import rbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  desc_t wr_data,
    output logic  q_full,
    input  logic  rd_en,
    output logic  q_empty,
    output desc_t rd_data
);

    desc_t            store_reg [Q_DEPTH];
    logic [QPW-1:0]   wp_reg, rp_reg;
    logic [QPW:0]     cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == (QPW+1)'(Q_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = store_reg[rp_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en)
            cnt_next = cnt_reg - 1'b1;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_reg[wp_reg] <= wr_data;
    end

endmodule

// ===== src/rbc_front.sv =====
// rbc_front: accepts pixels, clips them and sorts out edge and corner writes
// depends on rbc_pkg; feeds rbc_queue
module rbc_front
    import rbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        push,
    output logic        full,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    output logic        q_push,
    output desc_t       q_data,
    input  logic        q_full
);

    typedef logic signed [CW-1:0] crd_t;

    localparam crd_t FBW_C = CW'(FB_WIDTH);
    localparam crd_t FBH_C = CW'(FB_HEIGHT);

    // geometry derived from the settings, refreshed every cycle
    crd_t cl_reg, cr_reg, ct_reg, cb_reg;
    crd_t rx_reg, rxe_reg, ry_reg, rye_reg;
    crd_t hxl_reg, hxh_reg, vyl_reg, vyh_reg;
    crd_t lh_reg, rl_reg, th_reg, bl_reg, r_reg;
    logic kill_reg, rnz_reg;

    crd_t cl_next, cr_next, ct_next, cb_next;
    crd_t rx_next, rxe_next, ry_next, rye_next;
    crd_t r_next, b_next, cx, cxe, cy, cye;
    logic kill_next;

    always_comb
    begin
        rx_next  = {{(CW-16){cfg.rect_x_span[15]}}, cfg.rect_x_span[15:0]};
        ry_next  = {{(CW-16){cfg.rect_y_span[15]}}, cfg.rect_y_span[15:0]};
        rxe_next = rx_next + {{(CW-16){1'b0}}, cfg.rect_x_span[31:16]};
        rye_next = ry_next + {{(CW-16){1'b0}}, cfg.rect_y_span[31:16]};
        cx       = {{(CW-16){cfg.clip_x_span[15]}}, cfg.clip_x_span[15:0]};
        cy       = {{(CW-16){cfg.clip_y_span[15]}}, cfg.clip_y_span[15:0]};
        cxe      = cx + {{(CW-16){1'b0}}, cfg.clip_x_span[31:16]};
        cye      = cy + {{(CW-16){1'b0}}, cfg.clip_y_span[31:16]};
        r_next   = {{(CW-8){1'b0}}, cfg.corner_radius};
        b_next   = {{(CW-8){1'b0}}, cfg.border_thickness};
        // clip window cut to the buffer
        cl_next  = cx[CW-1] ? '0 : cx;
        ct_next  = cy[CW-1] ? '0 : cy;
        cr_next  = (cxe < FBW_C) ? cxe : FBW_C;
        cb_next  = (cye < FBH_C) ? cye : FBH_C;
        // nothing drawn at all
        kill_next = (b_next == '0) || (cl_next >= cr_next) || (ct_next >= cb_next)
                 || (((cl_next > rx_next) ? cl_next : rx_next)
                     >= ((cr_next < rxe_next) ? cr_next : rxe_next))
                 || (((ct_next > ry_next) ? ct_next : ry_next)
                     >= ((cb_next < rye_next) ? cb_next : rye_next));
    end

    always_ff @(posedge clk)
    begin
        cl_reg   <= cl_next;
        cr_reg   <= cr_next;
        ct_reg   <= ct_next;
        cb_reg   <= cb_next;
        rx_reg   <= rx_next;
        rxe_reg  <= rxe_next;
        ry_reg   <= ry_next;
        rye_reg  <= rye_next;
        hxl_reg  <= rx_next + r_next;
        hxh_reg  <= rxe_next - r_next;
        vyl_reg  <= ry_next + r_next;
        vyh_reg  <= rye_next - r_next;
        lh_reg   <= rx_next + b_next;
        rl_reg   <= rxe_next - b_next;
        th_reg   <= ry_next + b_next;
        bl_reg   <= rye_next - b_next;
        r_reg    <= r_next;
        rnz_reg  <= (cfg.corner_radius != 8'd0);
        kill_reg <= kill_next;
    end

    // all three stages move together, held while stage c holds a descriptor and the queue is full
    logic adv;
    logic c_v_reg;
    desc_t c_desc_reg;

    assign adv    = !(c_v_reg && q_full);
    assign full   = !adv;
    assign q_push = c_v_reg;
    assign q_data = c_desc_reg;

    // stage a: captured pixel
    logic        a_v_reg;
    logic [11:0] a_x_reg, a_y_reg;

    // stage b: clip, edges and corner offsets
    crd_t px, py;
    logic go;
    logic [3:0] edg;
    logic cok;
    crd_t ddx [4];
    crd_t ddy [4];
    logic [3:0] cv;

    always_comb
    begin
        px  = {{(CW-12){1'b0}}, a_x_reg};
        py  = {{(CW-12){1'b0}}, a_y_reg};
        go  = !kill_reg && (px >= cl_reg) && (px < cr_reg) && (py >= ct_reg) && (py < cb_reg);
        edg[0] = (px >= hxl_reg) && (px < hxh_reg) && (py >= ry_reg) && (py < th_reg);
        edg[1] = (px >= rx_reg) && (px < lh_reg) && (py >= vyl_reg) && (py < vyh_reg);
        edg[2] = (px >= rl_reg) && (px < rxe_reg) && (py >= vyl_reg) && (py < vyh_reg);
        edg[3] = (px >= hxl_reg) && (px < hxh_reg) && (py >= bl_reg) && (py < rye_reg);
        cok = (edg == 4'd0) && rnz_reg && (px >= rx_reg) && (px < rxe_reg)
           && (py >= ry_reg) && (py < rye_reg);
        // corners top-left, top-right, bottom-right, bottom-left
        ddx[0] = hxl_reg - 1'b1 - px;
        ddy[0] = vyl_reg - 1'b1 - py;
        ddx[1] = px - hxh_reg;
        ddy[1] = ddy[0];
        ddx[2] = ddx[1];
        ddy[2] = py - vyh_reg;
        ddx[3] = ddx[0];
        ddy[3] = ddy[2];
        for (int c = 0; c < 4; c++)
            cv[c] = cok && !ddx[c][CW-1] && (ddx[c] < r_reg)
                        && !ddy[c][CW-1] && (ddy[c] < r_reg);
    end

    logic        b_v_reg;
    logic [11:0] b_x_reg, b_y_reg;
    logic [3:0]  b_e_reg, b_cv_reg;
    logic [7:0]  b_dx_reg [4];
    logic [7:0]  b_dy_reg [4];

    // stage c: count and order the writes
    logic [17:0] key [4];
    logic [1:0]  rank [4];
    logic [2:0]  ne, nc;
    desc_t       c_desc_next;

    always_comb
    begin
        ne = '0;
        nc = '0;
        for (int c = 0; c < 4; c++)
        begin
            ne = ne + {2'b0, b_e_reg[c]};
            nc = nc + {2'b0, b_cv_reg[c]};
            key[c] = {b_dy_reg[c], b_dx_reg[c], 2'(c)};
        end
        for (int c = 0; c < 4; c++)
        begin
            rank[c] = '0;
            for (int j = 0; j < 4; j++)
                if (j != c && b_cv_reg[j] && key[j] < key[c])
                    rank[c] = rank[c] + 1'b1;
        end
        c_desc_next.x = b_x_reg;
        c_desc_next.y = b_y_reg;
        for (int s = 0; s < 4; s++)
        begin
            c_desc_next.slot[s].corner = 1'b0;
            c_desc_next.slot[s].dx     = '0;
            c_desc_next.slot[s].dy     = '0;
        end
        if (ne != '0)
            c_desc_next.cnt = ne;
        else
        begin
            c_desc_next.cnt = nc;
            for (int s = 0; s < 4; s++)
                for (int c = 0; c < 4; c++)
                    if (b_cv_reg[c] && rank[c] == 2'(s))
                    begin
                        c_desc_next.slot[s].corner = 1'b1;
                        c_desc_next.slot[s].dx     = b_dx_reg[c];
                        c_desc_next.slot[s].dy     = b_dy_reg[c];
                    end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= push;
            b_v_reg <= a_v_reg && go;
            c_v_reg <= b_v_reg && (c_desc_next.cnt != 3'd0);
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_x_reg    <= pixel_x;
            a_y_reg    <= pixel_y;
            b_x_reg    <= a_x_reg;
            b_y_reg    <= a_y_reg;
            b_e_reg    <= edg;
            b_cv_reg   <= cv;
            for (int c = 0; c < 4; c++)
            begin
                b_dx_reg[c] <= ddx[c][7:0];
                b_dy_reg[c] <= ddy[c][7:0];
            end
            c_desc_reg <= c_desc_next;
        end
    end

endmodule

// ===== src/rbc_back.sv =====
// rbc_back: issues one write per cycle unless stalled, works out corner coverage
// and queues results; depends on rbc_pkg; drains rbc_queue
module rbc_back
    import rbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_empty,
    input  desc_t q_data,
    output logic  q_pop,
    output logic  empty,
    input  logic  pop,
    output res_t  res_data
);

    typedef struct packed {
        logic [11:0]   x;
        logic [11:0]   y;
        logic          last;
        logic          is_const;
        logic [QW-1:0] cval;
        logic [DW-1:0] rem;
        logic [DW-1:0] den2;
        logic [QW-1:0] nrest;
        logic [QW-1:0] q;
    } dstage_t;

    // one restoring division step
    function automatic dstage_t div_step(dstage_t s);
        dstage_t     o;
        logic [DW:0] t;
        o = s;
        t = {s.rem, s.nrest[QW-1]};
        if (t >= {1'b0, s.den2})
        begin
            o.rem = DW'(t - {1'b0, s.den2});
            o.q   = {s.q[QW-2:0], 1'b1};
        end
        else
        begin
            o.rem = t[DW-1:0];
            o.q   = {s.q[QW-2:0], 1'b0};
        end
        o.nrest = {s.nrest[QW-2:0], 1'b0};
        return o;
    endfunction

    // corner zone thresholds from radius and thickness
    logic [7:0]      ri, rim1, rom1;
    logic [15:0]     sq_a, sq_b, sq_c, sq_d;
    logic [DSQW-1:0] thr_a_reg, thr_b_reg, thr_c_reg, thr_d_reg;
    logic [NUMW-1:0] den_i_reg, den_o_reg;
    logic            ri_nz_reg;

    always_comb
    begin
        ri   = (cfg.corner_radius > cfg.border_thickness)
             ? cfg.corner_radius - cfg.border_thickness : 8'd0;
        rim1 = ri - 8'd1;
        rom1 = cfg.corner_radius - 8'd1;
        sq_a = rim1 * rim1;
        sq_b = ri * ri;
        sq_c = rom1 * rom1;
        sq_d = cfg.corner_radius * cfg.corner_radius;
    end

    always_ff @(posedge clk)
    begin
        thr_a_reg <= {1'b0, sq_a};
        thr_b_reg <= {1'b0, sq_b};
        thr_c_reg <= {1'b0, sq_c};
        thr_d_reg <= {1'b0, sq_d};
        den_i_reg <= {ri, 1'b0} - 1'b1;
        den_o_reg <= {cfg.corner_radius, 1'b0} - 1'b1;
        ri_nz_reg <= (ri != 8'd0);
    end

    // issue: one write a cycle while a descriptor waits and result space is free
    logic [1:0]   k_reg;
    logic [OPW:0] outst_reg;
    logic         issue, last_slot, pop_out;
    slot_t        cur;

    assign issue     = !q_empty && (outst_reg < (OPW+1)'(OF_DEPTH));
    assign last_slot = ({1'b0, k_reg} == q_data.cnt - 3'd1);
    assign q_pop     = issue && last_slot;
    assign cur       = q_data.slot[k_reg];
    assign pop_out   = pop && !empty;

    // p0 issued write, p1 squared distance
    logic            p0_v_reg, p1_v_reg;
    logic [11:0]     p0_x_reg, p0_y_reg, p1_x_reg, p1_y_reg;
    logic            p0_last_reg, p1_last_reg, p0_cor_reg, p1_cor_reg;
    logic [7:0]      p0_dx_reg, p0_dy_reg;
    logic [DSQW-1:0] p1_d_reg;
    logic [15:0]     sx, sy;

    assign sx = p0_dx_reg * p0_dx_reg;
    assign sy = p0_dy_reg * p0_dy_reg;

    // p2 zone choice and ratio operands
    logic [NUMW-1:0] num, den;
    logic [NW-1:0]   nfull;
    dstage_t         d0;

    always_comb
    begin
        num         = '0;
        den         = NUMW'(1);
        d0.is_const = 1'b1;
        d0.cval     = '0;
        if (!p1_cor_reg)
            d0.cval = FULL_COV;
        else if (ri_nz_reg && p1_d_reg < thr_a_reg)
            d0.cval = '0;
        else if (ri_nz_reg && p1_d_reg < thr_b_reg)
        begin
            d0.is_const = 1'b0;
            num         = NUMW'(p1_d_reg - thr_a_reg);
            den         = den_i_reg;
        end
        else if (p1_d_reg < thr_c_reg)
            d0.cval = FULL_COV;
        else if (p1_d_reg < thr_d_reg)
        begin
            d0.is_const = 1'b0;
            num         = NUMW'(thr_d_reg - p1_d_reg);
            den         = den_o_reg;
        end
        // rounded ratio: (2 num full + den) / (2 den)
        nfull    = (NW'(num) << QW) + NW'(den);
        d0.x     = p1_x_reg;
        d0.y     = p1_y_reg;
        d0.last  = p1_last_reg;
        d0.rem   = nfull[NW-1:QW];
        d0.nrest = nfull[QW-1:0];
        d0.den2  = {den, 1'b0};
        d0.q     = '0;
    end

    // divider stages: the operands, then one quotient bit in each later stage
    dstage_t     dv_reg [QW+1];
    logic [QW:0] dv_v_reg;

    // result queue
    res_t           of_reg [OF_DEPTH];
    logic [OPW-1:0] of_wp_reg, of_rp_reg;
    logic [OPW:0]   of_cnt_reg;
    res_t           of_wdata;
    logic           of_wr;

    assign of_wr          = dv_v_reg[QW];
    assign of_wdata.x     = dv_reg[QW].x;
    assign of_wdata.y     = dv_reg[QW].y;
    assign of_wdata.last  = dv_reg[QW].last;
    assign of_wdata.cov   = sat_cov(dv_reg[QW].is_const ? dv_reg[QW].cval : dv_reg[QW].q);
    assign empty          = (of_cnt_reg == '0);
    assign res_data       = of_reg[of_rp_reg];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg      <= '0;
            outst_reg  <= '0;
            p0_v_reg   <= 1'b0;
            p1_v_reg   <= 1'b0;
            dv_v_reg   <= '0;
            of_wp_reg  <= '0;
            of_rp_reg  <= '0;
            of_cnt_reg <= '0;
        end
        else
        begin
            if (q_pop)
                k_reg <= '0;
            else if (issue)
                k_reg <= k_reg + 1'b1;
            outst_reg  <= outst_reg + {{OPW{1'b0}}, issue} - {{OPW{1'b0}}, pop_out};
            p0_v_reg   <= issue;
            p1_v_reg   <= p0_v_reg;
            dv_v_reg   <= {dv_v_reg[QW-1:0], p1_v_reg};
            if (of_wr)
                of_wp_reg <= of_wp_reg + 1'b1;
            if (pop_out)
                of_rp_reg <= of_rp_reg + 1'b1;
            of_cnt_reg <= of_cnt_reg + {{OPW{1'b0}}, of_wr} - {{OPW{1'b0}}, pop_out};
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        p0_x_reg    <= q_data.x;
        p0_y_reg    <= q_data.y;
        p0_last_reg <= last_slot;
        p0_cor_reg  <= cur.corner;
        p0_dx_reg   <= cur.dx;
        p0_dy_reg   <= cur.dy;
        p1_x_reg    <= p0_x_reg;
        p1_y_reg    <= p0_y_reg;
        p1_last_reg <= p0_last_reg;
        p1_cor_reg  <= p0_cor_reg;
        p1_d_reg    <= {1'b0, sx} + {1'b0, sy};
        dv_reg[0]   <= d0;
        for (int i = 1; i <= QW; i++)
            dv_reg[i] <= div_step(dv_reg[i-1]);
        if (of_wr)
            of_reg[of_wp_reg] <= of_wdata;
    end

endmodule

// ===== src/rounded_border_coverage.sv =====
// rounded_border_coverage: antialiased rounded rectangle border, top level
// depends on rbc_pkg, rbc_front, rbc_queue, rbc_back
//
// Usage
//  Settings are written through cfg_we/cfg_index/cfg_data while the block is idle.
//  Pixels enter on push/full: a pixel is taken at a clock edge with push high and
//  full low. Each pixel yields zero to four writes (edge writes, or corner writes
//  in drawing order if it is on no edge), leaving on empty/pop; last_write marks
//  the final write. out_color carries draw_color.
//  Throughput: one write per cycle while result space is free, so a pixel with at
//  most one write is taken every cycle; a pixel with n writes holds the back end
//  until all n are issued, and the four-entry descriptor queue absorbs short bursts.
//  Path: a pixel passes the three front stages, the queue, the squaring stage
//  and the nine-step coverage divider before its writes reach the result ports.
//  When the receiver stalls the 16-entry result queue fills, issue stops, the
//  descriptor queue fills and full rises. Reset empties every queue and
//  returns the settings to their defaults (border thickness one, others zero).
module rounded_border_coverage
    import rbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [11:0]       pixel_x,
    input  logic [11:0]       pixel_y,
    output logic              empty,
    input  logic              pop,
    output logic [11:0]       out_x,
    output logic [11:0]       out_y,
    output logic [8:0]        coverage,
    output logic [31:0]       out_color,
    output logic              last_write
);

    // settings
    logic [31:0] rect_x_span_reg, rect_y_span_reg, clip_x_span_reg, clip_y_span_reg;
    logic [7:0]  corner_radius_reg, border_thickness_reg;
    logic [31:0] draw_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_x_span_reg      <= '0;
            rect_y_span_reg      <= '0;
            clip_x_span_reg      <= '0;
            clip_y_span_reg      <= '0;
            corner_radius_reg    <= '0;
            border_thickness_reg <= 8'd1;
            draw_color_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RECT_X: rect_x_span_reg      <= cfg_data;
                REG_RECT_Y: rect_y_span_reg      <= cfg_data;
                REG_CLIP_X: clip_x_span_reg      <= cfg_data;
                REG_CLIP_Y: clip_y_span_reg      <= cfg_data;
                REG_RADIUS: corner_radius_reg    <= cfg_data[7:0];
                REG_BORDER: border_thickness_reg <= cfg_data[7:0];
                REG_COLOR:  draw_color_reg       <= cfg_data;
                default:    ;
            endcase
        end
    end

    cfg_t cfg;

    assign cfg.rect_x_span      = rect_x_span_reg;
    assign cfg.rect_y_span      = rect_y_span_reg;
    assign cfg.clip_x_span      = clip_x_span_reg;
    assign cfg.clip_y_span      = clip_y_span_reg;
    assign cfg.corner_radius    = corner_radius_reg;
    assign cfg.border_thickness = border_thickness_reg;

    // front, descriptor queue, back
    logic  q_push, q_full, q_pop, q_empty;
    desc_t q_wdata, q_rdata;
    res_t  res_data;

    rbc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .push    (push),
        .full    (full),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .q_push  (q_push),
        .q_data  (q_wdata),
        .q_full  (q_full)
    );

    rbc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push && !q_full),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (q_rdata)
    );

    rbc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .res_data (res_data)
    );

    // result word
    assign out_x      = res_data.x;
    assign out_y      = res_data.y;
    assign coverage   = res_data.cov;
    assign last_write = res_data.last;
    assign out_color  = draw_color_reg;

    // checks
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("descriptor taken from an empty queue");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (q_push && q_full))
        else $error("front stalled without a full descriptor queue");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_full) |=> q_push)
        else $error("stalled descriptor dropped");

endmodule
